>>> hw/rtl/kts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_pkg: shared types and constants of the key/tag batch sorter
// Entry layout of a sorting cell, cell control struct and FSM encoding.
// ----------------------------------------------------------------------------
package kts_pkg;

  localparam int KEY_W     = 24;
  localparam int TAG_W     = 16;
  localparam int SLOTS_DEF = 64;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [TAG_W-1:0] tag_t;

  typedef struct packed {
    logic valid;
    key_t key;
    tag_t tag;
  } entry_t;

  // Chain-wide control, same for every cell
  typedef struct packed {
    logic insert;     // place the broadcast pair, shift larger keys up
    logic shift_out;  // move every entry one cell towards the output
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

endpackage : kts_pkg

>>> hw/rtl/kts_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_cell: one sorting cell of the insertion chain
// Holds a single (key, tag) entry. On insert it keeps its entry, takes the
// new pair or takes its lower neighbour's entry; on emit it takes the entry
// of its upper neighbour.
// ----------------------------------------------------------------------------
module kts_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  kts_pkg::cell_ctrl_t ctrl,
  input  kts_pkg::entry_t     new_ent,
  input  kts_pkg::entry_t     left_ent,
  input  logic                left_gt,
  input  kts_pkg::entry_t     right_ent,
  output kts_pkg::entry_t     ent,
  output logic                gt
);
  import kts_pkg::*;

  logic valid_r, valid_nxt;
  key_t key_r, key_nxt;
  tag_t tag_r, tag_nxt;

  // An empty cell behaves as an infinitely large key; strict compare keeps
  // equal keys in arrival order.
  assign gt = !valid_r || (key_r > new_ent.key);

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    tag_nxt   = tag_r;
    if (ctrl.insert) begin
      if (gt && !left_gt) begin
        valid_nxt = 1'b1;
        key_nxt   = new_ent.key;
        tag_nxt   = new_ent.tag;
      end else if (gt) begin
        valid_nxt = left_ent.valid;
        key_nxt   = left_ent.key;
        tag_nxt   = left_ent.tag;
      end
    end else if (ctrl.shift_out) begin
      valid_nxt = right_ent.valid;
      key_nxt   = right_ent.key;
      tag_nxt   = right_ent.tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    tag_r <= tag_nxt;
  end

  assign ent.valid = valid_r;
  assign ent.key   = key_r;
  assign ent.tag   = tag_r;

endmodule : kts_cell

>>> hw/rtl/key_tag_batch_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_tag_batch_sorter: stable ascending key/tag batch sorter
// Insertion chain of SLOTS cells; a batch is loaded pair by pair and
// streamed out in ascending key order once its last pair arrives.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_key, in_tag, in_last
//  out_    | output    | out_valid/out_stall| out_key, out_tag, out_last,
//          |           |                    | out_overflow
//
//  Loading takes one pair per cycle; each cell compares its key with the
//  broadcast pair in parallel, so every cell decides its move on that pair.
//  After the last pair, the stored pairs of the batch leave in ascending order,
//  read from cell 0 while the chain shifts down. in_stall is high for
//  the whole emission. Synchronous active-low reset empties the chain.
//  Pairs beyond SLOTS are dropped and flagged on every result of the batch.
// ----------------------------------------------------------------------------
module key_tag_batch_sorter #(
  parameter int SLOTS = kts_pkg::SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  kts_pkg::key_t     in_key,
  input  kts_pkg::tag_t     in_tag,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_stall,
  output kts_pkg::key_t     out_key,
  output kts_pkg::tag_t     out_tag,
  output logic              out_last,
  output logic              out_overflow
);
  import kts_pkg::*;

  state_t     state_r, state_nxt;
  logic       overflow_r, overflow_nxt;
  cell_ctrl_t ctrl;
  entry_t     new_ent;
  entry_t     ent_w [SLOTS];
  logic       gt_w  [SLOTS];
  logic       in_acc, out_acc, full;

  assign in_stall  = (state_r != ST_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state_r == ST_EMIT);
  assign out_acc   = out_valid && !out_stall;
  assign full      = ent_w[SLOTS-1].valid;

  assign new_ent.valid  = 1'b1;
  assign new_ent.key    = in_key;
  assign new_ent.tag    = in_tag;
  assign ctrl.insert    = in_acc && !full;
  assign ctrl.shift_out = out_acc;

  genvar i;
  generate
    for (i = 0; i < SLOTS; i++) begin : g_cell
      entry_t left_ent, right_ent;
      logic   left_gt;
      if (i == 0) begin : g_first
        assign left_ent = '0;
        assign left_gt  = 1'b0;
      end else begin : g_mid_lo
        assign left_ent = ent_w[i-1];
        assign left_gt  = gt_w[i-1];
      end
      if (i == SLOTS-1) begin : g_last
        assign right_ent = '0;
      end else begin : g_mid_hi
        assign right_ent = ent_w[i+1];
      end
      kts_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .new_ent   (new_ent),
        .left_ent  (left_ent),
        .left_gt   (left_gt),
        .right_ent (right_ent),
        .ent       (ent_w[i]),
        .gt        (gt_w[i])
      );
    end
  endgenerate

  assign out_key      = ent_w[0].key;
  assign out_tag      = ent_w[0].tag;
  assign out_last     = !ent_w[1].valid;
  assign out_overflow = overflow_r;

  always_comb begin
    state_nxt    = state_r;
    overflow_nxt = overflow_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && full) overflow_nxt = 1'b1;
        if (in_acc && in_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_acc && out_last) begin
          state_nxt    = ST_LOAD;
          overflow_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt    = ST_LOAD;
        overflow_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      overflow_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      overflow_r <= overflow_nxt;
    end
  end

  // Emission always has an entry at the head of the chain
  a_emit_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> ent_w[0].valid)
    else $error("emitting from an empty chain");

  a_insert_head: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.insert |=> ent_w[0].valid)
    else $error("inserted pair not held in chain");

  a_batch_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last) |=> (!ent_w[0].valid && !overflow_r))
    else $error("chain not empty after final transaction");

  a_drop_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && full) |=> overflow_r)
    else $error("dropped pair not flagged");

endmodule : key_tag_batch_sorter

>>> dv/tb_key_tag_batch_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_tag_batch_sorter: self-checking bench for the key/tag batch sorter
// Batches of (key, tag) pairs go in through a queue-fed driver; a software
// insertion sort predicts each sorted batch and the monitor checks every
// result transaction field by field, including the full and overflow cases.
// ----------------------------------------------------------------------------
module tb_key_tag_batch_sorter;
  import kts_pkg::*;

  localparam int SLOTS       = SLOTS_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 20;

  typedef struct {
    key_t key;
    tag_t tag;
    logic last;
  } pair_t;

  typedef struct {
    key_t key;
    tag_t tag;
    logic last;
    logic overflow;
  } sorted_t;

  typedef enum int {
    KS_ANY,
    KS_NARROW,
    KS_EDGE,
    KS_MID
  } key_shape_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  key_t in_key = '0;
  tag_t in_tag = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  key_t out_key;
  tag_t out_tag;
  logic out_last;
  logic out_overflow;

  pair_t   pair_q[$];
  sorted_t sorted_q[$];

  // predictor state: the store as the block should hold it
  key_t held_key[SLOTS];
  tag_t held_tag[SLOTS];
  int   held_count = 0;
  bit   held_overflow = 1'b0;

  int   send_idle_pct = 19;
  int   recv_idle_pct = 81;
  bit   hold_start = 1'b0;
  int   hold_cnt = 0;
  logic in_taken = 1'b0;
  int   fail_count = 0;
  int   cycle_cnt = 0;

  key_tag_batch_sorter #(.SLOTS(SLOTS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_key      (in_key),
    .in_tag      (in_tag),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_key     (out_key),
    .out_tag     (out_tag),
    .out_last    (out_last),
    .out_overflow(out_overflow)
  );

  always #4 clk = ~clk;

  // Stable insertion: a new pair lands after every stored key <= its own
  function automatic void sort_insert_pair(input key_t key, input tag_t tag, input logic last);
    int pos;
    sorted_t s;
    if (held_count < SLOTS) begin
      pos = held_count;
      while (pos > 0 && held_key[pos-1] > key) begin
        held_key[pos] = held_key[pos-1];
        held_tag[pos] = held_tag[pos-1];
        pos--;
      end
      held_key[pos] = key;
      held_tag[pos] = tag;
      held_count++;
    end else begin
      held_overflow = 1'b1;
    end
    if (last) begin
      for (int k = 0; k < held_count; k++) begin
        s.key      = held_key[k];
        s.tag      = held_tag[k];
        s.last     = (k == held_count - 1);
        s.overflow = held_overflow;
        sorted_q.push_back(s);
      end
      held_count    = 0;
      held_overflow = 1'b0;
    end
  endfunction

  function automatic key_t pick_key();
    key_shape_t shape;
    key_t k;
    shape = key_shape_t'($urandom_range(3));
    case (shape)
      KS_ANY:    k = key_t'($urandom);
      KS_NARROW: k = key_t'($urandom_range(7));
      KS_EDGE:   k = $urandom_range(1) ? '1 : '0;
      default:   k = 24'h7FFFF8 + key_t'($urandom_range(15));
    endcase
    return k;
  endfunction

  function automatic void add_pair(input key_t key, input tag_t tag, input logic last);
    pair_t p;
    p.key  = key;
    p.tag  = tag;
    p.last = last;
    pair_q.push_back(p);
  endfunction

  function automatic int add_batch(input int n);
    for (int i = 0; i < n; i++)
      add_pair(pick_key(), tag_t'($urandom), i == n - 1);
    return n;
  endfunction

  // Idle means nothing queued, nothing on the input port and no result owed
  task automatic wait_idle();
    do @(posedge clk);
    while (pair_q.size() != 0 || in_valid || sorted_q.size() != 0);
  endtask

  // Driver: payload only moves once the current transaction has gone through
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pair_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_key   <= pair_q[0].key;
        in_tag   <= pair_q[0].tag;
        in_last  <= pair_q[0].last;
        in_valid <= 1'b1;
        void'(pair_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: one long hold-off in the last phase, random stalls otherwise
  always @(negedge clk) begin
    if (hold_start && hold_cnt < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor
  always @(posedge clk) begin
    sorted_t exp;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (sorted_q.size() == 0) begin
          $error("unexpected result transaction: key %h tag %h", out_key, out_tag);
          fail_count++;
        end else begin
          exp = sorted_q.pop_front();
          if (out_key !== exp.key) begin
            $error("out_key: expected %h, got %h", exp.key, out_key);
            fail_count++;
          end
          if (out_tag !== exp.tag) begin
            $error("out_tag: expected %h, got %h", exp.tag, out_tag);
            fail_count++;
          end
          if (out_last !== exp.last) begin
            $error("out_last: expected %b, got %b", exp.last, out_last);
            fail_count++;
          end
          if (out_overflow !== exp.overflow) begin
            $error("out_overflow: expected %b, got %b", exp.overflow, out_overflow);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        sort_insert_pair(in_key, in_tag, in_last);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int n;

    // single-pair batches at the key and tag extremes
    add_pair('0, '0, 1'b1);
    add_pair('1, '1, 1'b1);
    // reverse order, repeated keys, both extremes in one batch
    add_pair('1,          16'h0001, 1'b0);
    add_pair(24'h800000,  16'h8000, 1'b0);
    add_pair(24'h000005,  16'h0002, 1'b0);
    add_pair(24'h000005,  16'h0003, 1'b0);
    add_pair('0,          16'hFFFF, 1'b0);
    add_pair(24'h000005,  16'h0004, 1'b0);
    add_pair('1,          16'h0005, 1'b0);
    add_pair(24'h000001,  16'h0000, 1'b1);
    // all keys equal: arrival order must survive
    add_pair(24'h123456,  16'h0001, 1'b0);
    add_pair(24'h123456,  16'h0002, 1'b0);
    add_pair(24'h123456,  16'h0003, 1'b0);
    add_pair(24'h123456,  16'h0004, 1'b1);
    // alternating bit patterns
    add_pair(24'hAAAAAA,  16'h5555, 1'b0);
    add_pair(24'h555555,  16'hAAAA, 1'b1);

    n = 0;
    while (n < 35)
      n += add_batch($urandom_range(1, 8));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait_idle();
    send_idle_pct = 81;
    recv_idle_pct = 19;
    // store filled exactly, no overflow
    n = add_batch(SLOTS);
    n = 0;
    while (n < 15)
      n += add_batch($urandom_range(1, 8));

    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_start    = 1'b1;
    n = add_batch(6);
    // overflow: the extra pairs, the last one included, are dropped
    n = add_batch(SLOTS + $urandom_range(1, 4));
    n = 0;
    while (n < 15)
      n += add_batch($urandom_range(1, 8));

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/kts_pkg.sv
hw/rtl/kts_cell.sv
hw/rtl/key_tag_batch_sorter.sv
dv/tb_key_tag_batch_sorter.sv
